### sv/pbd_pkg.sv
package pbd_pkg;

	// field and register widths
	localparam int SAMPLE_W   = 10;
	localparam int IVL_W      = 13;
	localparam int RATE_W     = 8;
	localparam int MPS_W      = 4;
	localparam int BLANK_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// elapsed time never exceeds the longest timeout plus one step
	localparam int SINCE_W  = 14;
	localparam int MINUTE_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_DEFAULT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MS_PER_SAMPLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_BLANK    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEAT_TIMEOUT   = 2'd3;

	// register reset values
	localparam logic [SAMPLE_W-1:0] THRESH_DEFAULT_RST = 10'd550;
	localparam logic [MPS_W-1:0]    MS_PER_SAMPLE_RST  = 4'd2;
	localparam logic [BLANK_W-1:0]  NOISE_BLANK_RST    = 10'd250;
	localparam logic [IVL_W-1:0]    BEAT_TIMEOUT_RST   = 13'd2500;

	// detector constants
	localparam logic [SAMPLE_W-1:0] MIDSCALE      = SAMPLE_W'(1 << (SAMPLE_W - 1));
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {SAMPLE_W{1'b1}};
	localparam logic [IVL_W-1:0]    IVL_RESET     = 13'd600;
	localparam logic [IVL_W-1:0]    IVL_MAX       = {IVL_W{1'b1}};
	localparam logic [RATE_W-1:0]   RATE_MAX      = {RATE_W{1'b1}};
	localparam int                  MS_PER_MINUTE = 60000;
	localparam int                  SETTLE_DEN    = 5;
	localparam logic [IVL_W-1:0]    SETTLE_RESET  = IVL_W'((600 / SETTLE_DEN) * 3);
	localparam logic [SINCE_W-1:0]  SINCE_MAX     = SINCE_W'(8191 + 15);

endpackage

### sv/pulse_beat_detector_core.sv
// pulse beat detector: one converter sample in, one status item out
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   write registers only while the block is idle
// input channel: in_valid/in_ready with sample; in_ready is high while no
//   sample is being worked on
// output channel: out_valid/out_ready with bpm, beat_interval, pulse_high,
//   beat_strobe and threshold, one item per sample
// an ordinary sample passes through the EVAL and DONE states before out_valid;
//   a new sample is taken only once the last item has left the DONE state
// a beat that yields a rate sums the history in the SUM state, then takes
//   three passes of the shared bit-serial divider (sum / depth,
//   60000 / average, interval / 5)
// the discarded first beat costs one divider pass (interval / 5)
// the next sample is taken as soon as the result sits in the output register,
//   so a stalled receiver holds only one item; a second finished item waits
//   in the block and in_ready stays low until out_ready frees the register
// reset: registers return to their defaults, threshold 550, history cleared,
//   no beat pending, rate 0
module pulse_beat_detector_core
	import pbd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RATE_W-1:0]     bpm,
	output logic [IVL_W-1:0]      beat_interval,
	output logic                  pulse_high,
	output logic                  beat_strobe,
	output logic [SAMPLE_W-1:0]   threshold
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = IVL_W + CNT_W;
	localparam int DIV_W = (SUM_W > MINUTE_W) ? SUM_W : MINUTE_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EVAL   = 3'd1;
	localparam logic [2:0] ST_SUM    = 3'd2;
	localparam logic [2:0] ST_AVG    = 3'd3;
	localparam logic [2:0] ST_RATE   = 3'd4;
	localparam logic [2:0] ST_SETTLE = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [SAMPLE_W-1:0] thresh_default_q;
	logic [MPS_W-1:0]    mps_q;
	logic [BLANK_W-1:0]  blank_q;
	logic [IVL_W-1:0]    timeout_q;

	// detector state
	logic [SAMPLE_W-1:0] sample_q;
	logic [SINCE_W-1:0]  since_q;
	logic [IVL_W-1:0]    interval_q;
	logic [IVL_W-1:0]    settle_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [SAMPLE_W-1:0] trough_q;
	logic [SAMPLE_W-1:0] thresh_q;
	logic                in_pulse_q;
	logic                first_q;
	logic                second_q;
	logic [IVL_W-1:0]    hist_q [HISTORY_DEPTH];
	logic [RATE_W-1:0]   rate_q;
	logic                strobe_q;
	logic [SUM_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic                out_valid_q;
	logic [RATE_W-1:0]   bpm_q;
	logic [IVL_W-1:0]    interval_out_q;
	logic                pulse_out_q;
	logic                strobe_out_q;
	logic [SAMPLE_W-1:0] thresh_out_q;
	logic                out_free;

	// evaluation of the current sample
	logic                below;
	logic                above;
	logic                past_settle;
	logic [SAMPLE_W-1:0] peak_n;
	logic [SAMPLE_W-1:0] trough_n;
	logic                beat;
	logic                beat_end;
	logic                timed_out;
	logic [IVL_W-1:0]    ivl_sat;
	logic signed [SAMPLE_W:0]   amp;
	logic signed [SAMPLE_W:0]   half;
	logic signed [SAMPLE_W+1:0] mid_sum;
	logic [SAMPLE_W-1:0] mid_thresh;
	logic                sum_last;
	logic [SUM_W-1:0]    sum_final;

	// divider hookup
	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [IVL_W-1:0]    div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    div_quotient;
	logic [RATE_W-1:0]   rate_sat;
	logic [IVL_W-1:0]    quo_ivl;
	logic [IVL_W-1:0]    settle_n;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	assign below       = sample_q < thresh_q;
	assign above       = sample_q > thresh_q;
	assign past_settle = since_q > SINCE_W'(settle_q);

	assign trough_n = (below && past_settle && sample_q < trough_q) ? sample_q : trough_q;
	assign peak_n   = (above && sample_q > peak_q) ? sample_q : peak_q;

	assign beat = (since_q > SINCE_W'(blank_q)) && above && !in_pulse_q && past_settle;
	// a beat needs the sample above threshold, so it never ends in the same step
	assign beat_end  = below && in_pulse_q;
	assign timed_out = since_q > SINCE_W'(timeout_q);
	assign ivl_sat   = (since_q > SINCE_W'(IVL_MAX)) ? IVL_MAX : since_q[IVL_W-1:0];

	// midpoint of peak and trough, halving rounds toward zero
	assign amp        = $signed({1'b0, peak_n}) - $signed({1'b0, trough_n});
	assign half       = (amp + $signed({{SAMPLE_W{1'b0}}, amp[SAMPLE_W]})) >>> 1;
	assign mid_sum    = $signed({half[SAMPLE_W], half}) + $signed({2'b00, trough_n});
	assign mid_thresh = mid_sum[SAMPLE_W+1] ? '0 :
		(mid_sum[SAMPLE_W] ? SAMPLE_MAX : mid_sum[SAMPLE_W-1:0]);

	assign sum_last  = (cnt_q == CNT_W'(HISTORY_DEPTH - 1));
	assign sum_final = acc_q + SUM_W'(hist_q[0]);

	// a zero average divides to all ones and so saturates as well
	assign rate_sat = (div_quotient > DIV_W'(RATE_MAX)) ? RATE_MAX :
		div_quotient[RATE_W-1:0];
	assign quo_ivl  = div_quotient[IVL_W-1:0];
	assign settle_n = quo_ivl + (quo_ivl << 1);

	// the one divider serves the average, the rate and the settle time
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_EVAL: begin
				if (beat && first_q) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(ivl_sat);
					div_divisor  = IVL_W'(SETTLE_DEN);
				end
			end
			ST_SUM: begin
				if (sum_last) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(sum_final);
					div_divisor  = IVL_W'(HISTORY_DEPTH);
				end
			end
			ST_AVG: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(MS_PER_MINUTE);
					div_divisor  = quo_ivl;
				end
			end
			ST_RATE: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(interval_q);
					div_divisor  = IVL_W'(SETTLE_DEN);
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	pbd_div #(
		.DW(DIV_W),
		.VW(IVL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_default_q <= THRESH_DEFAULT_RST;
			mps_q            <= MS_PER_SAMPLE_RST;
			blank_q          <= NOISE_BLANK_RST;
			timeout_q        <= BEAT_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESH_DEFAULT: thresh_default_q <= cfg_data[SAMPLE_W-1:0];
				REG_MS_PER_SAMPLE:  mps_q            <= cfg_data[MPS_W-1:0];
				REG_NOISE_BLANK:    blank_q          <= cfg_data[BLANK_W-1:0];
				REG_BEAT_TIMEOUT:   timeout_q        <= cfg_data[IVL_W-1:0];
				default: begin
					mps_q <= mps_q;
				end
			endcase
		end
	end

	// sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			since_q    <= '0;
			interval_q <= IVL_RESET;
			settle_q   <= SETTLE_RESET;
			peak_q     <= MIDSCALE;
			trough_q   <= MIDSCALE;
			thresh_q   <= THRESH_DEFAULT_RST;
			in_pulse_q <= 1'b0;
			first_q    <= 1'b1;
			second_q   <= 1'b0;
			rate_q     <= '0;
			strobe_q   <= 1'b0;
			acc_q      <= '0;
			cnt_q      <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// elapsed time since the last beat advances by one step
						since_q <= since_q + SINCE_W'(mps_q);
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					strobe_q <= 1'b0;
					peak_q   <= peak_n;
					trough_q <= trough_n;
					state_q  <= ST_DONE;
					if (beat) begin
						in_pulse_q <= 1'b1;
						interval_q <= ivl_sat;
						since_q    <= '0;
						if (first_q) begin
							// first beat only starts the interval count and sets the settle time
							first_q  <= 1'b0;
							second_q <= 1'b1;
							state_q  <= ST_SETTLE;
						end else begin
							// second beat seeds every entry, later ones shift in
							for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
								hist_q[i] <= second_q ? ivl_sat : hist_q[i+1];
							end
							hist_q[HISTORY_DEPTH-1] <= ivl_sat;
							second_q <= 1'b0;
							acc_q    <= '0;
							cnt_q    <= '0;
							state_q  <= ST_SUM;
						end
					end else if (beat_end) begin
						in_pulse_q <= 1'b0;
						thresh_q   <= mid_thresh;
						peak_q     <= mid_thresh;
						trough_q   <= mid_thresh;
					end
					// no beat for too long: back to defaults, skipped on a first beat
					if (timed_out && !(beat && first_q)) begin
						thresh_q   <= thresh_default_q;
						peak_q     <= MIDSCALE;
						trough_q   <= MIDSCALE;
						since_q    <= '0;
						first_q    <= 1'b1;
						second_q   <= 1'b0;
						rate_q     <= '0;
						interval_q <= IVL_RESET;
						settle_q   <= SETTLE_RESET;
						in_pulse_q <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_SUM: begin
					// rotate the history once through the accumulator
					acc_q <= sum_final;
					for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HISTORY_DEPTH-1] <= hist_q[0];
					cnt_q <= cnt_q + 1'b1;
					if (sum_last) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_done) begin
						state_q <= ST_RATE;
					end
				end
				ST_RATE: begin
					if (div_done) begin
						rate_q   <= rate_sat;
						strobe_q <= 1'b1;
						state_q  <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					if (div_done) begin
						settle_q <= settle_n;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sample;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			bpm_q          <= rate_q;
			interval_out_q <= interval_q;
			pulse_out_q    <= in_pulse_q;
			strobe_out_q   <= strobe_q;
			thresh_out_q   <= thresh_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign bpm           = bpm_q;
	assign beat_interval = interval_out_q;
	assign pulse_high    = pulse_out_q;
	assign beat_strobe   = strobe_out_q;
	assign threshold     = thresh_out_q;

	// a fresh rate comes from an interval of at most 8191 ms, so it is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_strobe |-> bpm != '0)
		else $error("rate strobe with zero rate");

	// a rate is only computed on the beat that starts a pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_strobe |-> pulse_high)
		else $error("rate strobe outside a pulse");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(first_q && second_q))
		else $error("first and second beat both pending");

	// timeout keeps the elapsed time bounded
	assert property (@(posedge clk) disable iff (!arst_n)
		since_q <= SINCE_MAX)
		else $error("elapsed time past bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_AVG || state_q == ST_RATE || state_q == ST_SETTLE)
		else $error("divider result with nobody waiting");

endmodule

### sv/pbd_div.sv
module pbd_div #(
	parameter int DW = 17,
	parameter int VW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    den_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;
	logic             fit;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fit};
			rem_q <= fit ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
